// ===== hdl/dbgtr_pkg.sv =====
// Shared types, codes and constants for the debug breakpoint and opcode trap unit.
`timescale 1ns / 1ps

package dbgtr_pkg;

	// Field widths
	localparam int ACT_W  = 3;
	localparam int ADDR_W = 16;
	localparam int OPC_W  = 8;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;

	// Opcode trap map size, one bit per opcode
	localparam int TRAP_ENTRIES = 1 << OPC_W;

	// Default breakpoint table depth
	localparam int BKPT_DEPTH_DEF = 16;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_CHECK    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD      = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SET_TRAP = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLR_TRAP = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLR_ALL  = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

	// Request beat
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [ADDR_W-1:0] address;
		logic [OPC_W-1:0]  opcode;
		logic              cpu_idle;
	} dbgtr_req_t;

	// Response beat
	typedef struct packed {
		logic              stop;
		logic              breakpoint_hit;
		logic              trap_hit;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  entry_count;
	} dbgtr_rsp_t;

	// Token that walks the cell row, one cell per cycle
	typedef struct packed {
		logic              active;
		logic [ACT_W-1:0]  action;
		logic [ADDR_W-1:0] address;
		logic              hit;
		logic              found;
	} dbgtr_sweep_t;

	// Trap map commands
	typedef struct packed {
		logic             set;
		logic             clr;
		logic             clr_all;
		logic             rd;
		logic [OPC_W-1:0] opcode;
	} dbgtr_trap_cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_HOLD
	} dbgtr_state_t;

endpackage

// ===== hdl/dbgtr_trap.sv =====
// Opcode trap map with its wipe sequencer, and the generic RAM that stores the flags.
`timescale 1ns / 1ps

module dbgtr_ram #(
	parameter int Width = 1,
	parameter int Depth = 256,
	parameter int AddrW = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata_q
);

	logic [Width-1:0] mem_q [Depth];

	// Write one word, read one word into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

module dbgtr_trap (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dbgtr_pkg::dbgtr_trap_cmd_t cmd,
	output logic                       hit,
	output logic                       busy
);

	localparam int OpcW = dbgtr_pkg::OPC_W;
	localparam logic [OpcW-1:0] LastIdx = OpcW'(dbgtr_pkg::TRAP_ENTRIES - 1);

	logic [OpcW-1:0] wipe_idx_q;
	logic            wipe_q;
	logic            we;
	logic [OpcW-1:0] waddr;
	logic            wdata;

	assign busy = wipe_q;

	// Wipe writes take the port; edits only arrive once the wipe is over
	assign we    = wipe_q || cmd.set || cmd.clr;
	assign waddr = wipe_q ? wipe_idx_q : cmd.opcode;
	assign wdata = !wipe_q && cmd.set;

	// Sweep zeros through the map after reset and on clear all, one opcode per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_q     <= 1'b1;
			wipe_idx_q <= '0;
		end else if (cmd.clr_all) begin
			wipe_q     <= 1'b1;
			wipe_idx_q <= '0;
		end else if (wipe_q) begin
			wipe_idx_q <= wipe_idx_q + OpcW'(1);
			if (wipe_idx_q == LastIdx) begin
				wipe_q <= 1'b0;
			end
		end
	end

	// Flag storage, read on a check beat and held until the next one
	dbgtr_ram #(
		.Width (1),
		.Depth (dbgtr_pkg::TRAP_ENTRIES),
		.AddrW (OpcW)
	) u_map (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (cmd.rd),
		.raddr   (cmd.opcode),
		.rdata_q (hit)
	);

endmodule

// ===== hdl/dbgtr_cell.sv =====
// One breakpoint cell: holds one table entry and passes the token to its neighbour.
`timescale 1ns / 1ps

module dbgtr_cell #(
	parameter int Index = 0,
	parameter int CntW  = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dbgtr_pkg::dbgtr_sweep_t           sweep_in,
	input  logic [dbgtr_pkg::ADDR_W-1:0]      right_entry,
	input  logic [CntW-1:0]                   count,
	output dbgtr_pkg::dbgtr_sweep_t           sweep_q,
	output logic [dbgtr_pkg::ADDR_W-1:0]      entry_q
);

	localparam logic [CntW-1:0] IdxC = CntW'(Index);

	logic                            held;
	logic                            match;
	dbgtr_pkg::dbgtr_sweep_t         sweep_d;
	logic [dbgtr_pkg::ADDR_W-1:0]    entry_d;

	// Entry is live only below the count
	assign held  = IdxC < count;
	assign match = held && (entry_q == sweep_in.address);

	// Work on the passing token
	always_comb begin
		sweep_d = sweep_in;
		entry_d = entry_q;
		if (sweep_in.active) begin
			unique case (sweep_in.action)
				dbgtr_pkg::ACT_CHECK: begin
					sweep_d.hit = sweep_in.hit | match;
				end
				dbgtr_pkg::ACT_REMOVE: begin
					// from the first match onwards, pull the right neighbour down
					if (held && (sweep_in.found || match)) begin
						entry_d       = right_entry;
						sweep_d.found = 1'b1;
					end
				end
				dbgtr_pkg::ACT_ADD: begin
					if (IdxC == count) begin
						entry_d = sweep_in.address;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else begin
			sweep_q <= sweep_d;
		end
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ===== hdl/debug_breakpoint_and_opcode_trap_unit_top.sv =====
// Top level of the debug breakpoint and opcode trap unit.
//
//   Port group                  Dir  Handshake            Beat
//   req_valid/req_stall/req     in   valid/stall          dbgtr_req_t
//   rsp_valid/rsp_stall/rsp     out  valid/stall          dbgtr_rsp_t
//
// Check, add and remove hold off the next accept while a token walks the row of
// breakpoint cells, one cell per cycle.
// Trap edits and unused codes go straight to the hold state; after clear all the trap map
// is wiped one opcode per cycle before the next accept.
// After reset the request side stalls while the trap map is wiped.
// A result waiting on a stalled rsp holds the unit in its hold state.
`timescale 1ns / 1ps

module debug_breakpoint_and_opcode_trap_unit_top #(
	parameter int BREAKPOINT_DEPTH = dbgtr_pkg::BKPT_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  dbgtr_pkg::dbgtr_req_t req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output dbgtr_pkg::dbgtr_rsp_t rsp
);

	localparam int CntW = $clog2(BREAKPOINT_DEPTH + 1);
	localparam int ExtW = (CntW > dbgtr_pkg::CNT_W) ? CntW : dbgtr_pkg::CNT_W;
	localparam logic [CntW-1:0] DepthC = CntW'(BREAKPOINT_DEPTH);

	dbgtr_pkg::dbgtr_state_t     state_q, state_d;
	dbgtr_pkg::dbgtr_sweep_t     launch_q;
	dbgtr_pkg::dbgtr_sweep_t     launch_d;
	dbgtr_pkg::dbgtr_sweep_t     sweeps [BREAKPOINT_DEPTH+1];
	logic [dbgtr_pkg::ADDR_W-1:0] entries [BREAKPOINT_DEPTH];
	logic [BREAKPOINT_DEPTH:0]   actv;
	dbgtr_pkg::dbgtr_sweep_t     last;
	dbgtr_pkg::dbgtr_trap_cmd_t  trap_cmd;
	dbgtr_pkg::dbgtr_rsp_t       pend_q;
	dbgtr_pkg::dbgtr_rsp_t       pend_d;
	dbgtr_pkg::dbgtr_rsp_t       rsp_q;
	dbgtr_pkg::dbgtr_rsp_t       rsp_d;
	logic [CntW-1:0]             count_q;
	logic [ExtW-1:0]             count_ext;
	logic                        rsp_valid_q;
	logic                        idle_q;
	logic                        trap_rd;
	logic                        trap_busy;
	logic                        req_fire;
	logic                        walk_item;
	logic                        done;
	logic                        full;
	logic                        rsp_free;
	logic                        launch;
	logic                        move_out;

	assign req_fire  = req_valid && !req_stall;
	assign walk_item = req.action inside {dbgtr_pkg::ACT_CHECK, dbgtr_pkg::ACT_ADD,
		dbgtr_pkg::ACT_REMOVE};
	assign last      = sweeps[BREAKPOINT_DEPTH];
	assign done      = last.active;
	assign full      = count_q == DepthC;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign count_ext = ExtW'(count_q);

	// Trap map commands come straight from the accepted beat
	assign trap_cmd.set     = req_fire && (req.action == dbgtr_pkg::ACT_SET_TRAP);
	assign trap_cmd.clr     = req_fire && (req.action == dbgtr_pkg::ACT_CLR_TRAP);
	assign trap_cmd.clr_all = req_fire && (req.action == dbgtr_pkg::ACT_CLR_ALL);
	assign trap_cmd.rd      = req_fire && (req.action == dbgtr_pkg::ACT_CHECK);
	assign trap_cmd.opcode  = req.opcode;

	dbgtr_trap u_trap (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (trap_cmd),
		.hit    (trap_rd),
		.busy   (trap_busy)
	);

	// Row of breakpoint cells
	assign sweeps[0] = launch_q;

	for (genvar g = 0; g < BREAKPOINT_DEPTH; g++) begin : g_cell
		logic [dbgtr_pkg::ADDR_W-1:0] right;

		if (g == BREAKPOINT_DEPTH - 1) begin : g_end
			assign right = entries[g];
		end else begin : g_mid
			assign right = entries[g+1];
		end

		dbgtr_cell #(
			.Index (g),
			.CntW  (CntW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.sweep_in    (sweeps[g]),
			.right_entry (right),
			.count       (count_q),
			.sweep_q     (sweeps[g+1]),
			.entry_q     (entries[g])
		);
	end

	for (genvar a = 0; a <= BREAKPOINT_DEPTH; a++) begin : g_actv
		assign actv[a] = sweeps[a].active;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dbgtr_pkg::S_IDLE: begin
				if (req_fire) begin
					state_d = walk_item ? dbgtr_pkg::S_WALK : dbgtr_pkg::S_HOLD;
				end
			end
			dbgtr_pkg::S_WALK: begin
				if (done) begin
					state_d = dbgtr_pkg::S_HOLD;
				end
			end
			dbgtr_pkg::S_HOLD: begin
				if (rsp_free) begin
					state_d = dbgtr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dbgtr_pkg::S_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		req_stall = 1'b1;
		launch    = 1'b0;
		move_out  = 1'b0;
		unique case (state_q)
			dbgtr_pkg::S_IDLE: begin
				// hold off requests while the trap map is being wiped
				req_stall = trap_busy;
				launch    = req_fire && walk_item;
			end
			dbgtr_pkg::S_WALK: begin
			end
			dbgtr_pkg::S_HOLD: begin
				move_out = rsp_free;
			end
			default: begin
			end
		endcase
	end

	// Build the token for the cell row
	always_comb begin
		launch_d         = '0;
		launch_d.active  = launch;
		launch_d.action  = req.action;
		launch_d.address = req.address;
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dbgtr_pkg::S_IDLE;
			launch_q    <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;

			// Track the number of held breakpoints
			if (trap_cmd.clr_all) begin
				count_q <= '0;
			end else if (done && (last.action == dbgtr_pkg::ACT_ADD) && !full) begin
				count_q <= count_q + CntW'(1);
			end else if (done && (last.action == dbgtr_pkg::ACT_REMOVE) && last.found) begin
				count_q <= count_q - CntW'(1);
			end

			// Output beat valid
			if (move_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Build the pending result; the trap flag was read at accept and is held
	always_comb begin
		pend_d = pend_q;
		if (req_fire && !walk_item) begin
			pend_d = '{stop: 1'b0, breakpoint_hit: 1'b0, trap_hit: 1'b0,
				status: dbgtr_pkg::STAT_OK, entry_count: '0};
		end else if (done) begin
			pend_d = '{stop: 1'b0, breakpoint_hit: 1'b0, trap_hit: 1'b0,
				status: dbgtr_pkg::STAT_OK, entry_count: '0};
			case (last.action)
				dbgtr_pkg::ACT_CHECK: begin
					pend_d.breakpoint_hit = last.hit;
					pend_d.trap_hit       = trap_rd;
					pend_d.stop           = idle_q || last.hit || trap_rd;
				end
				dbgtr_pkg::ACT_ADD: begin
					pend_d.status = full ? dbgtr_pkg::STAT_FULL : dbgtr_pkg::STAT_OK;
				end
				dbgtr_pkg::ACT_REMOVE: begin
					pend_d.status = last.found ? dbgtr_pkg::STAT_OK
						: dbgtr_pkg::STAT_NOT_FOUND;
				end
				default: begin
				end
			endcase
		end
	end

	// Output beat with the settled count
	always_comb begin
		rsp_d             = pend_q;
		rsp_d.entry_count = count_ext[dbgtr_pkg::CNT_W-1:0];
	end

	// Capture check operands, the pending result and the output beat
	always_ff @(posedge clk) begin
		if (req_fire) begin
			idle_q <= req.cpu_idle;
		end

		pend_q <= pend_d;

		if (move_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// At most one token in the cell row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(actv))
		else $error("more than one token in the cell row");

	// Count never passes the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthC)
		else $error("breakpoint count beyond depth");

	// A token leaves the row only during a walk
	a_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == dbgtr_pkg::S_WALK))
		else $error("token left the row outside a walk");

	// Clear all empties the table
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		trap_cmd.clr_all |=> (count_q == '0))
		else $error("clear all left breakpoints held");

	// A free output takes the pending result
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		move_out |=> rsp_valid_q && (state_q == dbgtr_pkg::S_IDLE))
		else $error("pending result not presented");

endmodule

// ===== bench/tb_debug_breakpoint_and_opcode_trap_unit_top.sv =====
// Self-checking bench for the debug breakpoint and opcode trap unit: directed table, then random.
`timescale 1ns / 1ps

module tb_debug_breakpoint_and_opcode_trap_unit_top;

	localparam int ACT_W        = dbgtr_pkg::ACT_W;
	localparam int ADDR_W       = dbgtr_pkg::ADDR_W;
	localparam int OPC_W        = dbgtr_pkg::OPC_W;
	localparam int STAT_W       = dbgtr_pkg::STAT_W;
	localparam int CNT_W        = dbgtr_pkg::CNT_W;
	localparam int TRAP_ENTRIES = dbgtr_pkg::TRAP_ENTRIES;
	localparam int BKPT_DEPTH   = dbgtr_pkg::BKPT_DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RAND_BLOCKS  = 13;
	localparam int BLOCK_ITEMS  = 100;
	localparam int DRAIN_CYCLES = BKPT_DEPTH + 8;

	// Action codes with no defined behaviour
	localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

	typedef struct {
		dbgtr_pkg::dbgtr_req_t beat;
		int                    reps;
		bit                    pinned;
		dbgtr_pkg::dbgtr_rsp_t verdict;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	dbgtr_pkg::dbgtr_req_t req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	dbgtr_pkg::dbgtr_rsp_t rsp;

	// Shadow copy of the unit's state
	logic [ADDR_W-1:0]       bp_addr [BKPT_DEPTH];
	int                      bp_count;
	logic [TRAP_ENTRIES-1:0] trap_bits;

	dbgtr_pkg::dbgtr_rsp_t expected_verdicts [$];
	stim_row_t             directed [$];

	// Per-beat override used by directed rows with a typed-in result
	bit                    beat_pinned;
	dbgtr_pkg::dbgtr_rsp_t pinned_verdict;

	int  n_requests;
	int  n_verdicts;
	int  errors;
	int  cycles;
	int  n_checks, n_stops, n_bp_hits, n_trap_hits, n_full, n_missing;
	bit  quiet;

	logic [ADDR_W-1:0] addr_pool [8];
	logic [OPC_W-1:0]  opc_pool [4];

	debug_breakpoint_and_opcode_trap_unit_top #(
		.BREAKPOINT_DEPTH(BKPT_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Compute the verdict for one request and advance the shadow state
	function automatic dbgtr_pkg::dbgtr_rsp_t debug_outcome(input dbgtr_pkg::dbgtr_req_t r);
		dbgtr_pkg::dbgtr_rsp_t o;
		int                    hit_at;
		o = '0;
		o.status = dbgtr_pkg::STAT_OK;
		hit_at = -1;
		case (r.action)
			dbgtr_pkg::ACT_CHECK: begin
				for (int i = 0; i < bp_count; i++)
					if (bp_addr[i] == r.address)
						o.breakpoint_hit = 1'b1;
				o.trap_hit = trap_bits[r.opcode];
				o.stop = r.cpu_idle | o.breakpoint_hit | o.trap_hit;
			end
			dbgtr_pkg::ACT_ADD: begin
				if (bp_count >= BKPT_DEPTH) begin
					o.status = dbgtr_pkg::STAT_FULL;
				end else begin
					bp_addr[bp_count] = r.address;
					bp_count++;
				end
			end
			dbgtr_pkg::ACT_REMOVE: begin
				for (int i = 0; i < bp_count; i++)
					if (hit_at < 0 && bp_addr[i] == r.address)
						hit_at = i;
				if (hit_at < 0) begin
					o.status = dbgtr_pkg::STAT_NOT_FOUND;
				end else begin
					for (int j = hit_at; j + 1 < bp_count; j++)
						bp_addr[j] = bp_addr[j + 1];
					bp_count--;
				end
			end
			dbgtr_pkg::ACT_SET_TRAP: trap_bits[r.opcode] = 1'b1;
			dbgtr_pkg::ACT_CLR_TRAP: trap_bits[r.opcode] = 1'b0;
			dbgtr_pkg::ACT_CLR_ALL: begin
				bp_count = 0;
				trap_bits = '0;
			end
			default: ;
		endcase
		o.entry_count = CNT_W'(bp_count);
		return o;
	endfunction

	function automatic dbgtr_pkg::dbgtr_req_t req_of(input logic [ACT_W-1:0] a,
			input logic [ADDR_W-1:0] ad, input logic [OPC_W-1:0] op, input logic idle);
		dbgtr_pkg::dbgtr_req_t r;
		r.action = a;
		r.address = ad;
		r.opcode = op;
		r.cpu_idle = idle;
		return r;
	endfunction

	function automatic stim_row_t plain(input dbgtr_pkg::dbgtr_req_t r, input int reps = 1);
		stim_row_t s;
		s.beat = r;
		s.reps = reps;
		s.pinned = 1'b0;
		s.verdict = '0;
		return s;
	endfunction

	function automatic stim_row_t pinned(input dbgtr_pkg::dbgtr_req_t r, input logic stop,
			input logic bp, input logic tr, input logic [STAT_W-1:0] st,
			input logic [CNT_W-1:0] cnt);
		stim_row_t s;
		s.beat = r;
		s.reps = 1;
		s.pinned = 1'b1;
		s.verdict.stop = stop;
		s.verdict.breakpoint_hit = bp;
		s.verdict.trap_hit = tr;
		s.verdict.status = st;
		s.verdict.entry_count = cnt;
		return s;
	endfunction

	function automatic int draw_gap();
		if (quiet)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// Mostly well-formed traffic: hit held addresses and hot opcodes often
	function automatic dbgtr_pkg::dbgtr_req_t random_request();
		dbgtr_pkg::dbgtr_req_t r;
		int                    pick;
		int                    sel;
		r.address = ADDR_W'($urandom);
		r.opcode = OPC_W'($urandom);
		r.cpu_idle = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 3);
		if (pick < 40) begin
			r.action = dbgtr_pkg::ACT_CHECK;
			r.cpu_idle = ($urandom_range(0, 3) == 0);
		end else if (pick < 62) begin
			r.action = dbgtr_pkg::ACT_ADD;
		end else if (pick < 78) begin
			r.action = dbgtr_pkg::ACT_REMOVE;
		end else if (pick < 87) begin
			r.action = dbgtr_pkg::ACT_SET_TRAP;
		end else if (pick < 95) begin
			r.action = dbgtr_pkg::ACT_CLR_TRAP;
		end else if (pick < 98) begin
			r.action = dbgtr_pkg::ACT_CLR_ALL;
		end else begin
			r.action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
		end
		if (sel != 0) begin
			if (sel < 3 && bp_count > 0 && r.action != dbgtr_pkg::ACT_ADD)
				r.address = bp_addr[$urandom_range(0, bp_count - 1)];
			else
				r.address = addr_pool[$urandom_range(0, 7)];
			r.opcode = opc_pool[$urandom_range(0, 3)];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Present one request beat and hold it until it is taken
	task automatic send_beat(input dbgtr_pkg::dbgtr_req_t r, input bit pin,
			input dbgtr_pkg::dbgtr_rsp_t v);
		int gap;
		int target;
		gap = draw_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = r;
		beat_pinned = pin;
		pinned_verdict = v;
		req_valid = 1'b1;
		target = n_requests + 1;
		do @(negedge clk); while (n_requests < target);
	endtask

	task automatic wait_drained();
		while (expected_verdicts.size() != 0)
			@(negedge clk);
	endtask

	// Scoreboard and handshake monitor
	always @(posedge clk) begin
		dbgtr_pkg::dbgtr_rsp_t want;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				if (req_valid && !req_stall) begin
					want = debug_outcome(req);
					if (req.action == dbgtr_pkg::ACT_CHECK) begin
						n_checks++;
						n_stops += want.stop;
						n_bp_hits += want.breakpoint_hit;
						n_trap_hits += want.trap_hit;
					end
					if (want.status == dbgtr_pkg::STAT_FULL)
						n_full++;
					if (want.status == dbgtr_pkg::STAT_NOT_FOUND)
						n_missing++;
					expected_verdicts.push_back(beat_pinned ? pinned_verdict : want);
					n_requests++;
				end
				if (rsp_valid && !rsp_stall) begin
					if (expected_verdicts.size() == 0) begin
						$display("%0t: response with nothing pending, got %p", $time, rsp);
						errors++;
					end else begin
						want = expected_verdicts.pop_front();
						check_field("stop", ADDR_W'(want.stop), ADDR_W'(rsp.stop));
						check_field("breakpoint_hit", ADDR_W'(want.breakpoint_hit),
							ADDR_W'(rsp.breakpoint_hit));
						check_field("trap_hit", ADDR_W'(want.trap_hit),
							ADDR_W'(rsp.trap_hit));
						check_field("status", ADDR_W'(want.status), ADDR_W'(rsp.status));
						check_field("entry_count", ADDR_W'(want.entry_count),
							ADDR_W'(rsp.entry_count));
					end
					n_verdicts++;
				end
			end
		end
	end

	// Receiver: stall a random number of cycles before each response beat
	initial begin
		int seen;
		int hold;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			seen = n_verdicts;
			hold = draw_gap();
			if (hold > 0) begin
				rsp_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall = 1'b0;
			do @(negedge clk); while (n_verdicts == seen);
		end
	end

	// Stimulus
	initial begin
		dbgtr_pkg::dbgtr_req_t r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		beat_pinned = 1'b0;
		pinned_verdict = '0;
		n_requests = 0;
		n_verdicts = 0;
		errors = 0;
		cycles = 0;
		n_checks = 0;
		n_stops = 0;
		n_bp_hits = 0;
		n_trap_hits = 0;
		n_full = 0;
		n_missing = 0;
		quiet = 1'b0;
		bp_count = 0;
		trap_bits = '0;
		foreach (bp_addr[i])
			bp_addr[i] = '0;

		// Directed rows: reset state, extremes, duplicates, full table, clear all
		directed.push_back(pinned(req_of(dbgtr_pkg::ACT_CHECK, 16'h0000, 8'h00, 1'b0),
			1'b0, 1'b0, 1'b0, dbgtr_pkg::STAT_OK, 5'd0));
		directed.push_back(pinned(req_of(dbgtr_pkg::ACT_CHECK, 16'hffff, 8'hff, 1'b1),
			1'b1, 1'b0, 1'b0, dbgtr_pkg::STAT_OK, 5'd0));
		directed.push_back(pinned(req_of(dbgtr_pkg::ACT_REMOVE, 16'h1234, 8'h00, 1'b0),
			1'b0, 1'b0, 1'b0, dbgtr_pkg::STAT_NOT_FOUND, 5'd0));
		directed.push_back(pinned(req_of(dbgtr_pkg::ACT_SET_TRAP, 16'h0000, 8'h00, 1'b1),
			1'b0, 1'b0, 1'b0, dbgtr_pkg::STAT_OK, 5'd0));
		directed.push_back(pinned(req_of(dbgtr_pkg::ACT_CHECK, 16'h0000, 8'h00, 1'b0),
			1'b1, 1'b0, 1'b1, dbgtr_pkg::STAT_OK, 5'd0));
		directed.push_back(pinned(req_of(dbgtr_pkg::ACT_ADD, 16'h0000, 8'hff, 1'b1),
			1'b0, 1'b0, 1'b0, dbgtr_pkg::STAT_OK, 5'd1));
		directed.push_back(pinned(req_of(dbgtr_pkg::ACT_ADD, 16'hffff, 8'h00, 1'b0),
			1'b0, 1'b0, 1'b0, dbgtr_pkg::STAT_OK, 5'd2));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_ADD, 16'hffff, 8'h00, 1'b0)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_CHECK, 16'hffff, 8'h01, 1'b0)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_REMOVE, 16'hffff, 8'h00, 1'b1)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_CHECK, 16'hffff, 8'hff, 1'b0)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_SET_TRAP, 16'hffff, 8'hff, 1'b0)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_CHECK, 16'h5a5a, 8'hff, 1'b0)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_CLR_TRAP, 16'h0000, 8'hff, 1'b1)));
		directed.push_back(plain(req_of(ACT_SPARE_6, 16'hffff, 8'hff, 1'b1)));
		directed.push_back(plain(req_of(ACT_SPARE_7, 16'h0000, 8'h00, 1'b1)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_ADD, 16'h1000, 8'h00, 1'b0),
			BKPT_DEPTH - 2));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_ADD, 16'habcd, 8'h00, 1'b0)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_CHECK, 16'h100d, 8'h00, 1'b0)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_REMOVE, 16'h1000, 8'h00, 1'b0)));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_CHECK, 16'h1000, 8'h00, 1'b0)));
		directed.push_back(pinned(req_of(dbgtr_pkg::ACT_CLR_ALL, 16'hffff, 8'hff, 1'b1),
			1'b0, 1'b0, 1'b0, dbgtr_pkg::STAT_OK, 5'd0));
		directed.push_back(pinned(req_of(dbgtr_pkg::ACT_CHECK, 16'h0000, 8'h00, 1'b0),
			1'b0, 1'b0, 1'b0, dbgtr_pkg::STAT_OK, 5'd0));
		directed.push_back(plain(req_of(dbgtr_pkg::ACT_ADD, 16'h0000, 8'h00, 1'b0)));

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table; repeated rows step the address
		foreach (directed[n]) begin
			for (int k = 0; k < directed[n].reps; k++) begin
				r = directed[n].beat;
				r.address = r.address + ADDR_W'(k);
				send_beat(r, directed[n].pinned, directed[n].verdict);
			end
		end
		beat_pinned = 1'b0;

		// Hold off the sender until the unit has answered everything
		req_valid = 1'b0;
		wait_drained();

		// Random blocks, each with fresh hot values and its own idling mode
		for (int b = 0; b < RAND_BLOCKS; b++) begin
			quiet = ($urandom_range(0, 3) == 0);
			foreach (addr_pool[i])
				addr_pool[i] = ADDR_W'($urandom);
			foreach (opc_pool[i])
				opc_pool[i] = OPC_W'($urandom);
			for (int k = 0; k < BLOCK_ITEMS; k++)
				send_beat(random_request(), 1'b0, '0);
			if (b % 4 == 3) begin
				req_valid = 1'b0;
				wait_drained();
			end
		end
		quiet = 1'b0;
		req_valid = 1'b0;

		// Drain and let the unit settle
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d requests: %0d checks (%0d stops, %0d breakpoint hits, %0d trap hits),",
			n_requests, n_checks, n_stops, n_bp_hits, n_trap_hits);
		$display("%0d adds to a full table, %0d removes of absent addresses, %0d errors",
			n_full, n_missing, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
